/* design/slot_pool_ordered_active_list_unit_assert.svh */
// Assertion macros for the slot pool unit.
// Used by slot_pool_ordered_active_list_unit; expects clock and reset in scope.
`ifndef SLOT_POOL_ORDERED_ACTIVE_LIST_UNIT_ASSERT_SVH
`define SLOT_POOL_ORDERED_ACTIVE_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define SPOAL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spoal assertion failed");

// next-cycle implication
`define SPOAL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spoal assertion failed");

`endif

/* design/spoal_pkg.sv */
// Shared types and constants for the slot pool unit.
// No dependencies.
package spoal_pkg;

   localparam int SLOT_W        = 6;
   localparam int OP_W          = 2;
   localparam int LIMIT_W       = 7;
   localparam int CNT_OUT_W     = 7;
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC        = 2'd0,
      OP_RELEASE      = 2'd1,
      OP_READ_ACTIVE  = 2'd2,
      OP_READ_CREATED = 2'd3
   } spoal_op_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_COMMIT = 1'b1
   } spoal_state_type;

   // broadcast to every cell in the commit cycle
   typedef struct packed {
      logic shift_en;
      logic write_en;
   } spoal_cell_ctl_type;

endpackage

/* design/spoal_cell.sv */
// One entry of the ordered slot list: holds a slot id, compares, shifts down.
// Depends on spoal_pkg.
module spoal_cell #(
   parameter int POOL_DEPTH = spoal_pkg::DEPTH_DEFAULT,
   parameter int CELL_IDX   = 0
) (
   input  logic                              clock,
   input  spoal_pkg::spoal_cell_ctl_type     ctl,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]   act_cnt,
   input  logic [$clog2(POOL_DEPTH)-1:0]     pos,
   input  logic [$clog2(POOL_DEPTH)-1:0]     wr_idx,
   input  logic [spoal_pkg::SLOT_W-1:0]      wr_data,
   input  logic [spoal_pkg::SLOT_W-1:0]      next_entry,
   input  logic [spoal_pkg::SLOT_W-1:0]      rel_slot,
   input  logic [spoal_pkg::SLOT_W-1:0]      query_idx,
   output logic [spoal_pkg::SLOT_W-1:0]      entry,
   output logic                              match,
   output logic [spoal_pkg::SLOT_W-1:0]      hit_data,
   output logic [spoal_pkg::SLOT_W-1:0]      free_data
);

   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int QW    = (spoal_pkg::SLOT_W > IDX_W) ? spoal_pkg::SLOT_W : IDX_W;

   logic [spoal_pkg::SLOT_W-1:0] entry_ff;
   logic [spoal_pkg::SLOT_W-1:0] entry_in;
   logic                         is_active;

   assign is_active = CNT_W'(CELL_IDX) < act_cnt;
   assign match     = is_active && (entry_ff == rel_slot);
   assign hit_data  = (QW'(CELL_IDX) == QW'(query_idx)) ? entry_ff : '0;
   assign free_data = (CNT_W'(CELL_IDX) == act_cnt) ? entry_ff : '0;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.write_en && (IDX_W'(CELL_IDX) == wr_idx)) begin
         entry_in = wr_data;
      end else if (ctl.shift_en && (IDX_W'(CELL_IDX) >= pos) &&
                   (IDX_W'(CELL_IDX) < wr_idx)) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* design/slot_pool_ordered_active_list_unit.sv */
// Slot pool with an ordered active list: allocate, release and read of slot ids.
// Top level; depends on spoal_pkg, spoal_cell and the assertion macro header.
//
// Usage:
//  - Request channel (req_valid/req_ready) carries opcode, release slot and
//    query index. Response channel (rsp_valid/rsp_ready) returns status,
//    slot, found flag and the active and created totals after the request.
//  - csr_write_en/csr_write_data set the pool limit (reset 64); write only
//    while no request is in flight.
//  - Each request has an accept cycle, in which every cell of the list
//    compares its entry in parallel, and a commit cycle, in which the response
//    register loads and, on a found release, the cells above the freed position
//    shift down by one toward it. rsp_valid is registered and rises in the cycle
//    after the commit; a new request is taken only after the current one commits.
//  - A stalled response holds the commit: the block waits in commit until
//    the response register is free, then goes back to taking requests.
//  - Reset empties the pool (active and created counts zero, limit 64).
//    List entries are not cleared; an entry is always written before read.
`include "slot_pool_ordered_active_list_unit_assert.svh"

module slot_pool_ordered_active_list_unit #(
   parameter int POOL_DEPTH = spoal_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [spoal_pkg::OP_W-1:0]          req_opcode,
   input  logic [spoal_pkg::SLOT_W-1:0]        req_release_slot,
   input  logic [spoal_pkg::SLOT_W-1:0]        req_query_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [spoal_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic                                rsp_was_found,
   output logic [spoal_pkg::CNT_OUT_W-1:0]     rsp_active_total,
   output logic [spoal_pkg::CNT_OUT_W-1:0]     rsp_created_total,
   input  logic                                csr_write_en,
   input  logic [spoal_pkg::LIMIT_W-1:0]       csr_write_data
);

   localparam int SW    = spoal_pkg::SLOT_W;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CW0   = (spoal_pkg::LIMIT_W > CNT_W) ? spoal_pkg::LIMIT_W : CNT_W;
   localparam int CMP_W = (CW0 > SW) ? CW0 : SW;

   spoal_pkg::spoal_state_type state_ff, state_in;
   spoal_pkg::spoal_op_type    op_ff;
   logic [SW-1:0]              rel_ff;
   logic [SW-1:0]              idx_ff;
   logic                       found_ff;
   logic [IDX_W-1:0]           pos_ff;
   logic [SW-1:0]              rd_ff;
   logic [SW-1:0]              free_ff;
   logic [CNT_W-1:0]           act_cnt_ff, act_cnt_in;
   logic [CNT_W-1:0]           cre_cnt_ff, cre_cnt_in;
   logic [spoal_pkg::LIMIT_W-1:0] limit_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       status_ff, status_in;
   logic [SW-1:0]              slot_ff, slot_in;
   logic                       was_found_ff, was_found_in;

   logic                       accept;
   logic                       out_free;
   logic                       commit;
   logic                       alloc_ok;
   logic                       create;
   spoal_pkg::spoal_cell_ctl_type ctl;
   logic [IDX_W-1:0]           wr_idx;
   logic [SW-1:0]              wr_data;

   logic [SW-1:0]              entry     [POOL_DEPTH];
   logic [SW-1:0]              hit_data  [POOL_DEPTH];
   logic [SW-1:0]              free_data [POOL_DEPTH];
   logic [POOL_DEPTH-1:0]      match;
   logic [IDX_W-1:0]           pos_red;
   logic [SW-1:0]              rd_red;
   logic [SW-1:0]              free_red;

   // list of cells, each handing its entry to the one below
   for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
      logic [SW-1:0] nxt;
      if (g == POOL_DEPTH - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = entry[g+1];
      end
      spoal_cell #(
         .POOL_DEPTH (POOL_DEPTH),
         .CELL_IDX   (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .act_cnt    (act_cnt_ff),
         .pos        (pos_ff),
         .wr_idx     (wr_idx),
         .wr_data    (wr_data),
         .next_entry (nxt),
         .rel_slot   (req_release_slot),
         .query_idx  (req_query_index),
         .entry      (entry[g]),
         .match      (match[g]),
         .hit_data   (hit_data[g]),
         .free_data  (free_data[g])
      );
   end

   // active entries are distinct, so at most one match
   always_comb begin
      pos_red  = '0;
      rd_red   = '0;
      free_red = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         if (match[i]) pos_red = pos_red | IDX_W'(i);
         rd_red   = rd_red | hit_data[i];
         free_red = free_red | free_data[i];
      end
   end

   assign req_ready = (state_ff == spoal_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == spoal_pkg::ST_COMMIT) && out_free;
   assign alloc_ok  = (CMP_W'(act_cnt_ff) < CMP_W'(limit_ff)) &&
                      (act_cnt_ff < CNT_W'(POOL_DEPTH));
   assign create    = (act_cnt_ff == cre_cnt_ff);

   always_comb begin
      state_in     = state_ff;
      act_cnt_in   = act_cnt_ff;
      cre_cnt_in   = cre_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      was_found_in = was_found_ff;
      ctl          = '0;
      wr_idx       = IDX_W'(act_cnt_ff);
      wr_data      = SW'(cre_cnt_ff);
      unique case (state_ff)
         spoal_pkg::ST_IDLE: begin
            if (accept) state_in = spoal_pkg::ST_COMMIT;
         end
         spoal_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in     = spoal_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               slot_in      = '0;
               was_found_in = 1'b0;
               unique case (op_ff)
                  spoal_pkg::OP_ALLOC: begin
                     if (alloc_ok) begin
                        act_cnt_in = act_cnt_ff + CNT_W'(1);
                        if (create) begin
                           slot_in      = SW'(cre_cnt_ff);
                           ctl.write_en = 1'b1;
                           cre_cnt_in   = cre_cnt_ff + CNT_W'(1);
                        end else begin
                           slot_in = free_ff;
                        end
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  spoal_pkg::OP_RELEASE: begin
                     was_found_in = found_ff;
                     if (found_ff) begin
                        ctl.shift_en = 1'b1;
                        ctl.write_en = 1'b1;
                        wr_idx       = IDX_W'(act_cnt_ff - CNT_W'(1));
                        wr_data      = rel_ff;
                        act_cnt_in   = act_cnt_ff - CNT_W'(1);
                     end
                  end
                  spoal_pkg::OP_READ_ACTIVE: begin
                     if (CMP_W'(idx_ff) < CMP_W'(act_cnt_ff)) slot_in = rd_ff;
                     else status_in = 1'b1;
                  end
                  spoal_pkg::OP_READ_CREATED: begin
                     if (CMP_W'(idx_ff) < CMP_W'(cre_cnt_ff)) slot_in = idx_ff;
                     else status_in = 1'b1;
                  end
                  default: status_in = 1'b1;
               endcase
            end
         end
         default: state_in = spoal_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spoal_pkg::ST_IDLE;
         act_cnt_ff   <= '0;
         cre_cnt_ff   <= '0;
         limit_ff     <= spoal_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_cnt_ff   <= act_cnt_in;
         cre_cnt_ff   <= cre_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= spoal_pkg::spoal_op_type'(req_opcode);
         rel_ff   <= req_release_slot;
         idx_ff   <= req_query_index;
         found_ff <= |match;
         pos_ff   <= pos_red;
         rd_ff    <= rd_red;
         free_ff  <= free_red;
      end
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      was_found_ff <= was_found_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot_out      = slot_ff;
   assign rsp_was_found     = was_found_ff;
   assign rsp_active_total  = spoal_pkg::CNT_OUT_W'(act_cnt_ff);
   assign rsp_created_total = spoal_pkg::CNT_OUT_W'(cre_cnt_ff);

   `SPOAL_ASSERT_IMPL(a_act_le_cre, 1'b1, act_cnt_ff <= cre_cnt_ff)
   `SPOAL_ASSERT_NEXT(a_cre_monotonic, 1'b1, cre_cnt_ff >= $past(cre_cnt_ff))
   `SPOAL_ASSERT_NEXT(a_commit_done, commit, (state_ff == spoal_pkg::ST_IDLE) && rsp_valid_ff)
   `SPOAL_ASSERT_IMPL(a_one_match, state_ff == spoal_pkg::ST_IDLE, $onehot0(match))

endmodule
